@@ sv/lcg_pkg.sv @@
package lcg_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int ID_W      = 10;
    localparam int POS_W     = 32;
    localparam int MAG_W     = 32;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int LEN_W     = 31;
    localparam int LEN2_W    = 2 * LEN_W;
    localparam int REST_W    = 16;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int FRAC_BITS = 14;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIV_W     = MAG_W + FRAC_BITS + 2;
    localparam int NRM_W     = 16;

    localparam logic [QUO_W-1:0]  Q14_ONE  = QUO_W'(16384);
    localparam logic [REST_W-1:0] REST_MAX = REST_W'(32768);
    localparam logic [LEN_W-1:0]  PEN_MAX  = {LEN_W{1'b1}};

    // One link that produces a contact, as it waits between front and back
    typedef struct packed {
        logic [ID_W-1:0]          link_id;
        logic                     anchored;
        logic                     flip;
        logic [REST_W-1:0]        rest;
        logic [LEN_W-1:0]         len;
        logic [2:0]               neg;
        logic [2:0][MAG_W-1:0]    mag;
        logic [SUM_W-1:0]         sum_sq;
    } lcg_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lcg_qstat_t;

endpackage

@@ sv/link_contact_generator.sv @@
// Cable and rod contact generator. Takes one link per cycle while the queue
// has room (points A and B, kind, length, restitution) and emits at most one
// contact per link: a cable when |B - A| >= length, a rod when |B - A| !=
// length (normal flipped when compressed; restitution zero for every rod).
// Throughput is one link per clock while the queue has room. A contact
// passes through three front stages (difference, squares, sum), the handoff
// queue write, the queue read register that loads the root pipeline, 33
// stages of the bit-per-stage square root, one penetration stage, 15 stages
// of the restoring divide that forms the Q2.14 normal, and the output
// register.
// Links that produce no contact are dropped in the front and never reach
// the back. The front stalls only when the queue is full; the back stalls
// only when the output register holds an untaken contact.
module link_contact_generator
    import lcg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ID_W-1:0]          link_id,
    input  logic                     is_rod,
    input  logic                     is_anchored,
    input  logic signed [POS_W-1:0]  point_a_x,
    input  logic signed [POS_W-1:0]  point_a_y,
    input  logic signed [POS_W-1:0]  point_a_z,
    input  logic signed [POS_W-1:0]  point_b_x,
    input  logic signed [POS_W-1:0]  point_b_y,
    input  logic signed [POS_W-1:0]  point_b_z,
    input  logic [LEN_W-1:0]         link_length,
    input  logic [REST_W-1:0]        link_restitution,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ID_W-1:0]          contact_link_id,
    output logic                     contact_anchored,
    output logic signed [NRM_W-1:0]  normal_x,
    output logic signed [NRM_W-1:0]  normal_y,
    output logic signed [NRM_W-1:0]  normal_z,
    output logic [LEN_W-1:0]         penetration,
    output logic [REST_W-1:0]        contact_restitution
);

    logic       q_push, q_pop, q_room;
    lcg_item_t  q_in, q_out;
    lcg_qstat_t q_stat;

    // advance the front when the queue can take a request this cycle
    assign q_room = !q_stat.full || q_pop;

    lcg_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .link_id          (link_id),
        .is_rod           (is_rod),
        .is_anchored      (is_anchored),
        .point_a_x        (point_a_x),
        .point_a_y        (point_a_y),
        .point_a_z        (point_a_z),
        .point_b_x        (point_b_x),
        .point_b_y        (point_b_y),
        .point_b_z        (point_b_z),
        .link_length      (link_length),
        .link_restitution (link_restitution),
        .q_room           (q_room),
        .push             (q_push),
        .push_item        (q_in)
    );

    lcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .stat      (q_stat)
    );

    lcg_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_stat              (q_stat),
        .q_item              (q_out),
        .pop                 (q_pop),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .contact_link_id     (contact_link_id),
        .contact_anchored    (contact_anchored),
        .normal_x            (normal_x),
        .normal_y            (normal_y),
        .normal_z            (normal_z),
        .penetration         (penetration),
        .contact_restitution (contact_restitution)
    );

`ifndef SYNTHESIS
    // never push into a full queue unless it drains in the same cycle
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_stat.full || q_pop))
        else $error("queue overflow");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue underflow");

    // normal components stay within one unit
    a_unit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384
                    && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
                    && normal_z >= -16'sd16384 && normal_z <= 16'sd16384))
        else $error("normal out of range");
`endif

endmodule

@@ sv/lcg_front.sv @@
module lcg_front
    import lcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ID_W-1:0]          link_id,
    input  logic                     is_rod,
    input  logic                     is_anchored,
    input  logic signed [POS_W-1:0]  point_a_x,
    input  logic signed [POS_W-1:0]  point_a_y,
    input  logic signed [POS_W-1:0]  point_a_z,
    input  logic signed [POS_W-1:0]  point_b_x,
    input  logic signed [POS_W-1:0]  point_b_y,
    input  logic signed [POS_W-1:0]  point_b_z,
    input  logic [LEN_W-1:0]         link_length,
    input  logic [REST_W-1:0]        link_restitution,
    input  logic                     q_room,
    output logic                     push,
    output lcg_item_t                push_item
);

    logic                 adv;
    logic [POS_W-1:0]     pa [3];
    logic [POS_W-1:0]     pb [3];
    logic [POS_W:0]       diff [3];
    logic [MAG_W-1:0]     mag_c [3];
    logic [2:0]           neg_c;

    logic                 s1_v_reg, s2_v_reg, s3_v_reg;
    lcg_item_t            s1_item_reg, s2_item_reg, s3_item_reg;
    logic                 s1_rod_reg, s2_rod_reg, s3_rod_reg;
    logic [SQ_W-1:0]      s2_sq_reg [3];
    logic [LEN2_W-1:0]    s2_l2_reg, s3_l2_reg;
    logic [SUM_W-1:0]     s3_sum_reg;

    logic                 gt, eq, emit;
    logic [SUM_W-1:0]     l2_ext;

    assign adv      = q_room;
    assign in_ready = q_room;

    assign pa[0] = point_a_x;
    assign pa[1] = point_a_y;
    assign pa[2] = point_a_z;
    assign pb[0] = point_b_x;
    assign pb[1] = point_b_y;
    assign pb[2] = point_b_z;

    // d = B - A, kept as sign and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]  = {pb[i][POS_W-1], pb[i]} - {pa[i][POS_W-1], pa[i]};
            neg_c[i] = diff[i][POS_W];
            mag_c[i] = neg_c[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg.link_id  <= link_id;
            s1_item_reg.anchored <= is_anchored;
            s1_item_reg.flip     <= 1'b0;
            s1_item_reg.rest     <= (link_restitution > REST_MAX) ? REST_MAX
                                                                  : link_restitution;
            s1_item_reg.len      <= link_length;
            s1_item_reg.neg      <= neg_c;
            for (int i = 0; i < 3; i++)
                s1_item_reg.mag[i] <= mag_c[i];
            s1_item_reg.sum_sq   <= '0;
            s1_rod_reg           <= is_rod;

            for (int i = 0; i < 3; i++)
                s2_sq_reg[i] <= SQ_W'(s1_item_reg.mag[i] * s1_item_reg.mag[i]);
            s2_l2_reg   <= LEN2_W'(s1_item_reg.len * s1_item_reg.len);
            s2_item_reg <= s1_item_reg;
            s2_rod_reg  <= s1_rod_reg;

            s3_sum_reg  <= SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1])
                         + SUM_W'(s2_sq_reg[2]);
            s3_l2_reg   <= s2_l2_reg;
            s3_item_reg <= s2_item_reg;
            s3_rod_reg  <= s2_rod_reg;
        end
    end

    // classify: cable taut, or rod off its length
    assign l2_ext = SUM_W'(s3_l2_reg);
    assign gt     = s3_sum_reg > l2_ext;
    assign eq     = s3_sum_reg == l2_ext;
    assign emit   = s3_rod_reg ? !eq : (gt || eq);
    assign push   = adv && s3_v_reg && emit;

    always_comb
    begin
        push_item        = s3_item_reg;
        push_item.sum_sq = s3_sum_reg;
        push_item.flip   = s3_rod_reg && !gt;
        if (s3_rod_reg)
            push_item.rest = '0;
    end

endmodule

@@ sv/lcg_queue.sv @@
module lcg_queue
    import lcg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lcg_item_t  push_item,
    input  logic       pop,
    output lcg_item_t  pop_item,
    output lcg_qstat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lcg_item_t       ent_reg [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;

    assign pop_item   = ent_reg[rd_reg];
    assign stat.full  = cnt_reg == CW'(DEPTH);
    assign stat.empty = cnt_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= push_item;
    end

endmodule

@@ sv/lcg_back.sv @@
module lcg_back
    import lcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lcg_qstat_t               q_stat,
    input  lcg_item_t                q_item,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ID_W-1:0]          contact_link_id,
    output logic                     contact_anchored,
    output logic signed [NRM_W-1:0]  normal_x,
    output logic signed [NRM_W-1:0]  normal_y,
    output logic signed [NRM_W-1:0]  normal_z,
    output logic [LEN_W-1:0]         penetration,
    output logic [REST_W-1:0]        contact_restitution
);

    logic adv;

    logic                 sq_v_reg    [0:SQRT_STEPS];
    lcg_item_t            sq_item_reg [0:SQRT_STEPS];
    logic [REM_W-1:0]     sq_rem_reg  [0:SQRT_STEPS];
    logic [ROOT_W-1:0]    sq_root_reg [0:SQRT_STEPS];

    logic                 dv_v_reg    [0:QUO_W];
    lcg_item_t            dv_item_reg [0:QUO_W];
    logic [ROOT_W-1:0]    dv_dist_reg [0:QUO_W];
    logic [LEN_W-1:0]     dv_pen_reg  [0:QUO_W];
    logic [DIV_W-1:0]     dv_rem_reg  [0:QUO_W][0:2];
    logic [QUO_W-1:0]     dv_q_reg    [0:QUO_W][0:2];

    logic                 out_v_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_anch_reg;
    logic [NRM_W-1:0]     out_nrm_reg [3];
    logic [LEN_W-1:0]     out_pen_reg;
    logic [REST_W-1:0]    out_rest_reg;

    logic [ROOT_W-1:0]    dist_c, dgap_c;
    logic [ROOT_W-1:0]    len_ext;
    logic [LEN_W-1:0]     pen_c;
    logic [NRM_W-1:0]     nrm_c [3];

    assign adv = !out_v_reg || out_ready;
    assign pop = adv && !q_stat.empty;

    // valid chain for both the root and the divide pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQRT_STEPS; k++)
                sq_v_reg[k] <= 1'b0;
            for (int j = 0; j <= QUO_W; j++)
                dv_v_reg[j] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= pop;
            for (int k = 0; k < SQRT_STEPS; k++)
                sq_v_reg[k+1] <= sq_v_reg[k];
            dv_v_reg[0] <= sq_v_reg[SQRT_STEPS];
            for (int j = 0; j < QUO_W; j++)
                dv_v_reg[j+1] <= dv_v_reg[j];
            out_v_reg <= dv_v_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_item_reg[0] <= q_item;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_sqrt
            logic [REM_W+1:0] tmp, trial;
            logic             ge;
            lcg_item_t        nxt;

            always_comb
            begin
                tmp        = {sq_rem_reg[k], sq_item_reg[k].sum_sq[SUM_W-1 -: 2]};
                trial      = (REM_W+2)'({sq_root_reg[k], 2'b01});
                ge         = tmp >= trial;
                nxt        = sq_item_reg[k];
                nxt.sum_sq = {sq_item_reg[k].sum_sq[SUM_W-3:0], 2'b00};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_item_reg[k+1] <= nxt;
                    sq_rem_reg[k+1]  <= ge ? REM_W'(tmp - trial) : REM_W'(tmp);
                    sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], ge};
                end
            end
        end
    endgenerate

    // penetration and rounded numerators
    assign dist_c  = sq_root_reg[SQRT_STEPS];
    assign len_ext = ROOT_W'(sq_item_reg[SQRT_STEPS].len);
    assign dgap_c  = (dist_c >= len_ext) ? dist_c - len_ext : len_ext - dist_c;
    assign pen_c   = (dgap_c > ROOT_W'(PEN_MAX)) ? PEN_MAX : LEN_W'(dgap_c);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_item_reg[0] <= sq_item_reg[SQRT_STEPS];
            dv_dist_reg[0] <= dist_c;
            dv_pen_reg[0]  <= pen_c;
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= DIV_W'({sq_item_reg[SQRT_STEPS].mag[i],
                                            {FRAC_BITS{1'b0}}})
                                  + DIV_W'(dist_c[ROOT_W-1:1]);
                dv_q_reg[0][i]   <= '0;
            end
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    genvar j;
    generate
        for (j = 0; j < QUO_W; j++)
        begin : g_div
            logic [DIV_W-1:0] dsh;
            logic [2:0]       ge;

            always_comb
            begin
                dsh = DIV_W'(dv_dist_reg[j]) << (QUO_W - 1 - j);
                for (int i = 0; i < 3; i++)
                    ge[i] = dv_rem_reg[j][i] >= dsh;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_item_reg[j+1] <= dv_item_reg[j];
                    dv_dist_reg[j+1] <= dv_dist_reg[j];
                    dv_pen_reg[j+1]  <= dv_pen_reg[j];
                    for (int i = 0; i < 3; i++)
                    begin
                        dv_rem_reg[j+1][i] <= ge[i] ? dv_rem_reg[j][i] - dsh
                                                    : dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][QUO_W-2:0], ge[i]};
                    end
                end
            end
        end
    endgenerate

    // clamp, zero for coincident points, apply sign
    always_comb
    begin
        logic [QUO_W-1:0] qc;
        logic             ng;
        for (int i = 0; i < 3; i++)
        begin
            qc = (dv_q_reg[QUO_W][i] > Q14_ONE) ? Q14_ONE : dv_q_reg[QUO_W][i];
            if (dv_dist_reg[QUO_W] == '0)
                qc = '0;
            ng = dv_item_reg[QUO_W].neg[i] ^ dv_item_reg[QUO_W].flip;
            nrm_c[i] = ng ? -NRM_W'(qc) : NRM_W'(qc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_id_reg   <= dv_item_reg[QUO_W].link_id;
            out_anch_reg <= dv_item_reg[QUO_W].anchored;
            out_pen_reg  <= dv_pen_reg[QUO_W];
            out_rest_reg <= dv_item_reg[QUO_W].rest;
            for (int i = 0; i < 3; i++)
                out_nrm_reg[i] <= nrm_c[i];
        end
    end

    assign out_valid           = out_v_reg;
    assign contact_link_id     = out_id_reg;
    assign contact_anchored    = out_anch_reg;
    assign normal_x            = out_nrm_reg[0];
    assign normal_y            = out_nrm_reg[1];
    assign normal_z            = out_nrm_reg[2];
    assign penetration         = out_pen_reg;
    assign contact_restitution = out_rest_reg;

endmodule
